@@ hw/rtl/gtc_pkg.sv @@
// ----------------------------------------------------------------------------
// gtc_pkg
// shared types and constants of the grid transposition cipher
// ----------------------------------------------------------------------------
package gtc_pkg;

	localparam int MAX_LEN_DEF  = 56;
	localparam int MAX_ROWS_DEF = 8;
	localparam int GRID_DEPTH   = 64;
	localparam int ADDR_W       = 6;
	localparam int CNT_W        = 7;
	localparam int ROWS_W       = 4;

	localparam logic [7:0]  PAD_CHAR    = 8'h78;
	localparam logic        MODE_RST    = 1'b0;
	localparam logic [3:0]  ROWS_RST    = 4'd4;
	localparam logic [63:0] SHIFTS_RST  = 64'h0000_0000_0301_0201;

	typedef struct packed {
		logic [7:0] in_char;
		logic       last_char;
	} item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       has_char;
		logic       last_out;
		logic       overflow;
	} result_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_PASS,
		OP_DIV_COLS,
		OP_SET_COLS,
		OP_DIV_SH,
		OP_SET_SH,
		OP_FILL_RD,
		OP_FILL_WR,
		OP_SW_RD,
		OP_SW_WA,
		OP_SW_WB,
		OP_UN_RD,
		OP_UN_WR,
		OP_ST_RD,
		OP_ST_DEC,
		OP_OUT_RD,
		OP_OUT_EM,
		OP_EMPTY
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic mode;
		logic rows_zero;
		logic div_busy;
		logic bad_len;
		logic col_last;
		logic row_last;
		logic sw_last;
		logic len_zero;
		logic is_x;
		logic out_last;
	} stat_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_SETUP,
		S_COLS_WAIT,
		S_SH_START,
		S_SH_WAIT,
		S_FILL_RD,
		S_FILL_WR,
		S_SW_RD,
		S_SW_WA,
		S_SW_WB,
		S_UN_RD,
		S_UN_WR,
		S_ST_RD,
		S_ST_CK,
		S_OUT_RD,
		S_OUT_EM,
		S_EMPTY
	} state_t;

endpackage

@@ hw/rtl/gtc_div.sv @@
// ----------------------------------------------------------------------------
// gtc_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module gtc_div (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [7:0] dividend,
	input  logic [5:0] divisor,
	output logic       busy,
	output logic [7:0] quo,
	output logic [5:0] rem
);

	logic [3:0] cnt_q;
	logic [5:0] rem_q;
	logic [7:0] quo_q;
	logic [5:0] div_q;
	logic [6:0] trial;
	logic [6:0] diff;
	logic       ge;

	assign trial = {rem_q, quo_q[7]};
	assign ge    = trial >= {1'b0, div_q};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 4'd8;
		end else if (cnt_q != 4'd0) begin
			cnt_q <= cnt_q - 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (cnt_q != 4'd0) begin
			rem_q <= ge ? diff[5:0] : trial[5:0];
			quo_q <= {quo_q[6:0], ge};
		end
	end

	assign busy = cnt_q != 4'd0;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

@@ hw/rtl/gtc_datapath.sv @@
// ----------------------------------------------------------------------------
// gtc_datapath
// text and grid stores, loop counters and address arithmetic
// ----------------------------------------------------------------------------
module gtc_datapath #(
	parameter int MAX_LEN  = gtc_pkg::MAX_LEN_DEF,
	parameter int MAX_ROWS = gtc_pkg::MAX_ROWS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  gtc_pkg::cmd_t    cmd,
	input  gtc_pkg::item_t   item,
	input  logic             cfg_mode,
	input  logic [3:0]       cfg_rows,
	input  logic [63:0]      cfg_shifts,
	output gtc_pkg::stat_t   stat,
	output logic             result_valid,
	output gtc_pkg::result_t result
);

	localparam logic [gtc_pkg::CNT_W-1:0]  LEN_LIM  = gtc_pkg::CNT_W'(MAX_LEN);
	localparam logic [gtc_pkg::ROWS_W-1:0] ROWS_LIM = gtc_pkg::ROWS_W'(MAX_ROWS);

	logic [7:0] text_mem [gtc_pkg::GRID_DEPTH];
	logic [7:0] grid_mem [gtc_pkg::GRID_DEPTH];

	logic [gtc_pkg::CNT_W-1:0]  n_q, len_q, idx_q;
	logic                       ovf_q, pass_q, neg_q;
	logic [gtc_pkg::ROWS_W-1:0] rows_q, rows_eff;
	logic [5:0]                 cols_q, sh_q, i_q, j_q;
	logic [7:0]                 text_rd_q, ga_q, gb_q;

	logic                       div_start, div_busy;
	logic [7:0]                 div_dividend, div_quo;
	logic [5:0]                 div_divisor, div_rem;
	logic [7:0]                 sbyte, mag;
	logic [5:0]                 rows6, rows_m1, cols_m1, half, cs, kk, new_cols;
	logic [6:0]                 cs_sum, k_sum;
	logic [12:0]                p_full, g_cr, g_csr, t_rcs, sw_a, sw_b;
	logic                       p_in;

	logic                       t_we, t_re, g_we, g_rea, g_reb;
	logic [gtc_pkg::ADDR_W-1:0] t_wa, t_ra, g_wa, g_ra, g_rb;
	logic [7:0]                 t_wd, g_wd;

	gtc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.quo      (div_quo),
		.rem      (div_rem)
	);

	assign rows_eff = (cfg_rows > ROWS_LIM) ? ROWS_LIM : cfg_rows;
	assign rows6    = 6'(rows_q);
	assign rows_m1  = rows6 - 6'd1;
	assign cols_m1  = cols_q - 6'd1;
	assign half     = cols_q >> 1;

	// signed shift byte of the current row, as magnitude and direction
	assign sbyte = cfg_shifts[8*i_q[2:0] +: 8];
	assign mag   = sbyte[7] ? (~sbyte + 8'd1) : sbyte;

	assign div_start    = (cmd.op == gtc_pkg::OP_DIV_COLS) || (cmd.op == gtc_pkg::OP_DIV_SH);
	assign div_dividend = (cmd.op == gtc_pkg::OP_DIV_COLS) ? {1'b0, n_q} : mag;
	assign div_divisor  = (cmd.op == gtc_pkg::OP_DIV_COLS) ? 6'(rows_eff) : cols_q;
	assign new_cols     = (!cfg_mode && div_rem != 6'd0) ? div_quo[5:0] + 6'd1 : div_quo[5:0];

	// column after rotation and partner column of the swap, both modulo cols
	assign cs_sum = {1'b0, j_q} + {1'b0, sh_q};
	assign cs     = (cs_sum >= {1'b0, cols_q}) ? 6'(cs_sum - {1'b0, cols_q}) : cs_sum[5:0];
	assign k_sum  = {1'b0, half} + {1'b0, i_q};
	assign kk     = (k_sum >= {1'b0, cols_q}) ? 6'(k_sum - {1'b0, cols_q}) : k_sum[5:0];

	assign p_full = 13'(i_q) * 13'(cols_q) + 13'(j_q);
	assign g_cr   = 13'(j_q) * 13'(rows6) + 13'(i_q);
	assign g_csr  = 13'(cs) * 13'(rows6) + 13'(i_q);
	assign t_rcs  = 13'(i_q) * 13'(cols_q) + 13'(cs);
	assign sw_a   = 13'(i_q) * 13'(rows6) + 13'(j_q);
	assign sw_b   = 13'(kk) * 13'(rows6) + 13'(rows_m1 - j_q);
	assign p_in   = p_full < 13'(n_q);

	// memory port selection
	always_comb begin
		t_we  = 1'b0;
		t_wa  = n_q[gtc_pkg::ADDR_W-1:0];
		t_wd  = item.in_char;
		t_re  = 1'b0;
		t_ra  = p_full[gtc_pkg::ADDR_W-1:0];
		g_we  = 1'b0;
		g_wa  = sw_a[gtc_pkg::ADDR_W-1:0];
		g_wd  = gb_q;
		g_rea = 1'b0;
		g_reb = 1'b0;
		g_ra  = sw_a[gtc_pkg::ADDR_W-1:0];
		g_rb  = sw_b[gtc_pkg::ADDR_W-1:0];
		case (cmd.op)
			gtc_pkg::OP_LOAD: begin
				t_we = n_q < LEN_LIM;
			end
			gtc_pkg::OP_UN_WR: begin
				t_we = 1'b1;
				t_wa = t_rcs[gtc_pkg::ADDR_W-1:0];
				t_wd = ga_q;
			end
			gtc_pkg::OP_FILL_RD: begin
				t_re = 1'b1;
			end
			gtc_pkg::OP_ST_RD: begin
				t_re = 1'b1;
				t_ra = 6'(len_q - 7'd1);
			end
			gtc_pkg::OP_OUT_RD: begin
				t_re  = 1'b1;
				t_ra  = idx_q[gtc_pkg::ADDR_W-1:0];
				g_rea = 1'b1;
				g_ra  = g_cr[gtc_pkg::ADDR_W-1:0];
			end
			gtc_pkg::OP_FILL_WR: begin
				g_we = 1'b1;
				g_wa = cfg_mode ? g_cr[gtc_pkg::ADDR_W-1:0] : g_csr[gtc_pkg::ADDR_W-1:0];
				g_wd = p_in ? text_rd_q : gtc_pkg::PAD_CHAR;
			end
			gtc_pkg::OP_SW_RD: begin
				g_rea = 1'b1;
				g_reb = 1'b1;
			end
			gtc_pkg::OP_SW_WA: begin
				g_we = 1'b1;
			end
			gtc_pkg::OP_SW_WB: begin
				g_we = 1'b1;
				g_wa = sw_b[gtc_pkg::ADDR_W-1:0];
				g_wd = ga_q;
			end
			gtc_pkg::OP_UN_RD: begin
				g_rea = 1'b1;
				g_ra  = g_cr[gtc_pkg::ADDR_W-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (t_we) begin
			text_mem[t_wa] <= t_wd;
		end
		if (t_re) begin
			text_rd_q <= text_mem[t_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (g_we) begin
			grid_mem[g_wa] <= g_wd;
		end
		if (g_rea) begin
			ga_q <= grid_mem[g_ra];
		end
		if (g_reb) begin
			gb_q <= grid_mem[g_rb];
		end
	end

	// message length and overflow flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q   <= '0;
			ovf_q <= 1'b0;
		end else begin
			case (cmd.op)
				gtc_pkg::OP_LOAD: begin
					if (n_q < LEN_LIM) begin
						n_q <= n_q + 7'd1;
					end else begin
						ovf_q <= 1'b1;
					end
				end
				gtc_pkg::OP_OUT_EM: begin
					if (stat.out_last) begin
						n_q   <= '0;
						ovf_q <= 1'b0;
					end
				end
				gtc_pkg::OP_EMPTY: begin
					n_q   <= '0;
					ovf_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	// loop counters and per-message geometry
	always_ff @(posedge clk) begin
		case (cmd.op)
			gtc_pkg::OP_PASS: begin
				len_q  <= n_q;
				idx_q  <= '0;
				pass_q <= 1'b1;
			end
			gtc_pkg::OP_DIV_COLS: begin
				rows_q <= rows_eff;
			end
			gtc_pkg::OP_SET_COLS: begin
				cols_q <= new_cols;
				pass_q <= stat.bad_len;
				len_q  <= stat.bad_len ? n_q : 7'(rows6 * new_cols);
				idx_q  <= '0;
				i_q    <= '0;
				j_q    <= '0;
			end
			gtc_pkg::OP_DIV_SH: begin
				neg_q <= sbyte[7] ^ cfg_mode;
			end
			gtc_pkg::OP_SET_SH: begin
				if (div_rem == 6'd0) begin
					sh_q <= '0;
				end else begin
					sh_q <= neg_q ? cols_q - div_rem : div_rem;
				end
			end
			gtc_pkg::OP_FILL_WR: begin
				if (stat.col_last) begin
					if (stat.row_last) begin
						i_q <= cfg_mode ? cols_m1 : 6'd0;
						j_q <= cfg_mode ? rows_m1 : 6'd0;
					end else begin
						i_q <= i_q + 6'd1;
						j_q <= '0;
					end
				end else begin
					j_q <= j_q + 6'd1;
				end
			end
			gtc_pkg::OP_SW_WB: begin
				if (stat.sw_last) begin
					i_q <= '0;
					j_q <= '0;
				end else if (cfg_mode) begin
					if (j_q == 6'd0) begin
						j_q <= rows_m1;
						i_q <= i_q - 6'd1;
					end else begin
						j_q <= j_q - 6'd1;
					end
				end else begin
					if (j_q == rows_m1) begin
						j_q <= '0;
						i_q <= i_q + 6'd1;
					end else begin
						j_q <= j_q + 6'd1;
					end
				end
			end
			gtc_pkg::OP_UN_WR: begin
				if (stat.col_last) begin
					j_q <= '0;
					if (stat.row_last) begin
						i_q   <= '0;
						len_q <= n_q;
					end else begin
						i_q <= i_q + 6'd1;
					end
				end else begin
					j_q <= j_q + 6'd1;
				end
			end
			gtc_pkg::OP_ST_DEC: begin
				len_q <= len_q - 7'd1;
			end
			gtc_pkg::OP_OUT_EM: begin
				idx_q <= idx_q + 7'd1;
				if (stat.col_last) begin
					j_q <= '0;
					i_q <= i_q + 6'd1;
				end else begin
					j_q <= j_q + 6'd1;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		stat.mode      = cfg_mode;
		stat.rows_zero = rows_eff == '0;
		stat.div_busy  = div_busy;
		stat.bad_len   = cfg_mode && (div_rem != 6'd0);
		stat.col_last  = j_q == cols_m1;
		stat.row_last  = i_q == rows_m1;
		stat.sw_last   = cfg_mode ? (i_q == 6'd0 && j_q == 6'd0)
		                          : (i_q == cols_m1 && j_q == rows_m1);
		stat.len_zero  = len_q == '0;
		stat.is_x      = text_rd_q == gtc_pkg::PAD_CHAR;
		stat.out_last  = idx_q == len_q - 7'd1;
	end

	assign result_valid = (cmd.op == gtc_pkg::OP_OUT_EM) || (cmd.op == gtc_pkg::OP_EMPTY);

	always_comb begin
		if (cmd.op == gtc_pkg::OP_EMPTY) begin
			result.out_char = '0;
			result.has_char = 1'b0;
			result.last_out = 1'b1;
		end else begin
			result.out_char = (pass_q || cfg_mode) ? text_rd_q : ga_q;
			result.has_char = 1'b1;
			result.last_out = stat.out_last;
		end
		result.overflow = ovf_q;
	end

endmodule

@@ hw/rtl/gtc_ctrl.sv @@
// ----------------------------------------------------------------------------
// gtc_ctrl
// sequencer for load, geometry, fill, swaps, unrotate, strip and read-out
// ----------------------------------------------------------------------------
module gtc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           last,
	input  gtc_pkg::stat_t stat,
	output gtc_pkg::cmd_t  cmd,
	output logic           busy
);

	gtc_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gtc_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd.op  = gtc_pkg::OP_NONE;
		case (state_q)
			gtc_pkg::S_IDLE: begin
				if (start) begin
					cmd.op = gtc_pkg::OP_LOAD;
					if (last) begin
						state_d = gtc_pkg::S_SETUP;
					end
				end
			end
			gtc_pkg::S_SETUP: begin
				if (stat.rows_zero) begin
					cmd.op  = gtc_pkg::OP_PASS;
					state_d = gtc_pkg::S_OUT_RD;
				end else begin
					cmd.op  = gtc_pkg::OP_DIV_COLS;
					state_d = gtc_pkg::S_COLS_WAIT;
				end
			end
			gtc_pkg::S_COLS_WAIT: begin
				if (!stat.div_busy) begin
					cmd.op = gtc_pkg::OP_SET_COLS;
					if (stat.bad_len) begin
						state_d = gtc_pkg::S_OUT_RD;
					end else if (stat.mode) begin
						state_d = gtc_pkg::S_FILL_RD;
					end else begin
						state_d = gtc_pkg::S_SH_START;
					end
				end
			end
			gtc_pkg::S_SH_START: begin
				cmd.op  = gtc_pkg::OP_DIV_SH;
				state_d = gtc_pkg::S_SH_WAIT;
			end
			gtc_pkg::S_SH_WAIT: begin
				if (!stat.div_busy) begin
					cmd.op  = gtc_pkg::OP_SET_SH;
					state_d = stat.mode ? gtc_pkg::S_UN_RD : gtc_pkg::S_FILL_RD;
				end
			end
			gtc_pkg::S_FILL_RD: begin
				cmd.op  = gtc_pkg::OP_FILL_RD;
				state_d = gtc_pkg::S_FILL_WR;
			end
			gtc_pkg::S_FILL_WR: begin
				cmd.op = gtc_pkg::OP_FILL_WR;
				if (!stat.col_last) begin
					state_d = gtc_pkg::S_FILL_RD;
				end else if (stat.row_last) begin
					state_d = gtc_pkg::S_SW_RD;
				end else begin
					state_d = stat.mode ? gtc_pkg::S_FILL_RD : gtc_pkg::S_SH_START;
				end
			end
			gtc_pkg::S_SW_RD: begin
				cmd.op  = gtc_pkg::OP_SW_RD;
				state_d = gtc_pkg::S_SW_WA;
			end
			gtc_pkg::S_SW_WA: begin
				cmd.op  = gtc_pkg::OP_SW_WA;
				state_d = gtc_pkg::S_SW_WB;
			end
			gtc_pkg::S_SW_WB: begin
				cmd.op = gtc_pkg::OP_SW_WB;
				if (!stat.sw_last) begin
					state_d = gtc_pkg::S_SW_RD;
				end else begin
					state_d = stat.mode ? gtc_pkg::S_SH_START : gtc_pkg::S_OUT_RD;
				end
			end
			gtc_pkg::S_UN_RD: begin
				cmd.op  = gtc_pkg::OP_UN_RD;
				state_d = gtc_pkg::S_UN_WR;
			end
			gtc_pkg::S_UN_WR: begin
				cmd.op = gtc_pkg::OP_UN_WR;
				if (!stat.col_last) begin
					state_d = gtc_pkg::S_UN_RD;
				end else begin
					state_d = stat.row_last ? gtc_pkg::S_ST_RD : gtc_pkg::S_SH_START;
				end
			end
			gtc_pkg::S_ST_RD: begin
				if (stat.len_zero) begin
					state_d = gtc_pkg::S_EMPTY;
				end else begin
					cmd.op  = gtc_pkg::OP_ST_RD;
					state_d = gtc_pkg::S_ST_CK;
				end
			end
			gtc_pkg::S_ST_CK: begin
				if (stat.is_x) begin
					cmd.op  = gtc_pkg::OP_ST_DEC;
					state_d = gtc_pkg::S_ST_RD;
				end else begin
					state_d = gtc_pkg::S_OUT_RD;
				end
			end
			gtc_pkg::S_OUT_RD: begin
				cmd.op  = gtc_pkg::OP_OUT_RD;
				state_d = gtc_pkg::S_OUT_EM;
			end
			gtc_pkg::S_OUT_EM: begin
				cmd.op  = gtc_pkg::OP_OUT_EM;
				state_d = stat.out_last ? gtc_pkg::S_IDLE : gtc_pkg::S_OUT_RD;
			end
			gtc_pkg::S_EMPTY: begin
				cmd.op  = gtc_pkg::OP_EMPTY;
				state_d = gtc_pkg::S_IDLE;
			end
			default: begin
				state_d = gtc_pkg::S_IDLE;
			end
		endcase
	end

	assign busy = state_q != gtc_pkg::S_IDLE;

endmodule

@@ hw/rtl/grid_transposition_cipher.sv @@
// ----------------------------------------------------------------------------
// grid_transposition_cipher
// buffers a message, then permutes it through a row/column grid and streams
// the result back one byte per result
// ----------------------------------------------------------------------------
//
// channel  | signals                                 | transfer
// ---------+-----------------------------------------+-----------------------------
// request  | start, busy, item                       | start high while busy low
// result   | result_valid, result                    | one cycle strobe, no stall
// config   | psel penable pwrite paddr pwdata prdata | write on access phase
//
// a byte that is not last is taken while busy stays low
// the last byte starts the run; each stripped pad byte costs strip steps but
//   saves its read-out; the grid swaps and the divider wait used once per
//   row for the shift dominate
// reset clears the sequencer, byte count and overflow flag and sets the config
//   defaults; the stores are undefined until written and need no clearing pass
// results cannot be stalled: each byte is shown for exactly one cycle
// ----------------------------------------------------------------------------
module grid_transposition_cipher #(
	parameter int MAX_LEN  = gtc_pkg::MAX_LEN_DEF,
	parameter int MAX_ROWS = gtc_pkg::MAX_ROWS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	// configuration port
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [4:0]       paddr,
	input  logic [63:0]      pwdata,
	output logic [63:0]      prdata,
	output logic             pready,
	// request side
	input  logic             start,
	input  gtc_pkg::item_t   item,
	output logic             busy,
	// result side
	output logic             result_valid,
	output gtc_pkg::result_t result
);

	// register map, 64-bit registers on 8-byte spacing
	localparam logic [1:0] REG_MODE   = 2'd0;
	localparam logic [1:0] REG_ROWS   = 2'd1;
	localparam logic [1:0] REG_SHIFTS = 2'd2;

	logic            mode_q;
	logic [3:0]      rows_q;
	logic [63:0]     shifts_q;
	logic            wr_en;
	gtc_pkg::cmd_t   cmd;
	gtc_pkg::stat_t  stat;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	// configuration registers; the user must write them only while the block is idle, the block itself does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= gtc_pkg::MODE_RST;
			rows_q   <= gtc_pkg::ROWS_RST;
			shifts_q <= gtc_pkg::SHIFTS_RST;
		end else if (wr_en) begin
			case (paddr[4:3])
				REG_MODE:   mode_q   <= pwdata[0];
				REG_ROWS:   rows_q   <= pwdata[3:0];
				REG_SHIFTS: shifts_q <= pwdata;
				default: begin
				end
			endcase
		end
	end

	// read back
	always_comb begin
		case (paddr[4:3])
			REG_MODE:   prdata = {63'd0, mode_q};
			REG_ROWS:   prdata = {60'd0, rows_q};
			REG_SHIFTS: prdata = shifts_q;
			default:    prdata = '0;
		endcase
	end

	// sequencer: steps the datapath through each phase of the run
	gtc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.last   (item.last_char),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// stores, counters, divider and address arithmetic
	gtc_datapath #(
		.MAX_LEN  (MAX_LEN),
		.MAX_ROWS (MAX_ROWS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.item         (item),
		.cfg_mode     (mode_q),
		.cfg_rows     (rows_q),
		.cfg_shifts   (shifts_q),
		.stat         (stat),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

@@ hw/rtl/gtc_checker.sv @@
// ----------------------------------------------------------------------------
// gtc_checker
// port-level checks on request and result sequencing
// ----------------------------------------------------------------------------
module gtc_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input gtc_pkg::item_t   item,
	input logic             busy,
	input logic             result_valid,
	input gtc_pkg::result_t result
);

	// results only come out during a run
	a_result_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy)
		else $error("result outside a run");

	// a byte that is not last leaves the block free
	a_mid_byte_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !item.last_char) |=> !busy)
		else $error("busy after a mid-message byte");

	// the last byte starts a run
	a_last_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.last_char) |=> busy)
		else $error("last byte did not start a run");

	// the final result ends the run
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.last_out) |=> !busy)
		else $error("still busy after final result");

	// the empty marker is always the final result
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.has_char) |-> result.last_out)
		else $error("empty marker not final");

endmodule

bind grid_transposition_cipher gtc_checker u_gtc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.item         (item),
	.busy         (busy),
	.result_valid (result_valid),
	.result       (result)
);
